FILE: design/swm_pkg.sv
// ----------------------------------------------------------------------------
// swm_pkg
// Shared widths, types and helpers of the sliding-window median filter.
// ----------------------------------------------------------------------------
package swm_pkg;

  localparam int WINDOW_MAX = 64;
  localparam int DATA_W     = 32;
  localparam int IDX_W      = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int CNT_W      = 7;
  localparam logic [CNT_W-1:0] WS_RESET = CNT_W'(3);

  // data handed between neighboring sort cells
  typedef struct packed {
    logic signed [DATA_W-1:0] val;
    logic                     vld;
    logic                     le;
  } link_t;

  // common control seen by every sort cell
  typedef struct packed {
    logic signed [DATA_W-1:0] sample;
    logic signed [DATA_W-1:0] old_val;
    logic                     clear;
    logic                     remove;
    logic                     load;
    logic                     wipe;
  } cell_ctrl_t;

  // window size clamped to 1..WINDOW_MAX
  function automatic logic [CNT_W-1:0] eff_size(input logic [CNT_W-1:0] ws);
    logic [CNT_W-1:0] w;
    w = ws;
    if (w == '0) begin
      w = CNT_W'(1);
    end
    if (w > CNT_W'(WINDOW_MAX)) begin
      w = CNT_W'(WINDOW_MAX);
    end
    return w;
  endfunction

endpackage

FILE: design/swm_if.sv
// ----------------------------------------------------------------------------
// swm channel interfaces
// Valid/ready channels for sample items, median items and window size writes.
// ----------------------------------------------------------------------------
interface swm_in_if;
  logic                                     valid;
  logic                                     ready;
  logic signed [swm_pkg::DATA_W-1:0]        sample;
  logic                                     first_sample;
  modport source (output valid, output sample, output first_sample, input ready);
  modport sink   (input valid, input sample, input first_sample, output ready);
endinterface

interface swm_out_if;
  logic                                     valid;
  logic                                     ready;
  logic signed [swm_pkg::DATA_W-1:0]        median;
  modport source (output valid, output median, input ready);
  modport sink   (input valid, input median, output ready);
endinterface

interface swm_cfg_if;
  logic                                     valid;
  logic                                     ready;
  logic [swm_pkg::CNT_W-1:0]                window_size;
  modport source (output valid, output window_size, input ready);
  modport sink   (input valid, input window_size, output ready);
endinterface

FILE: design/swm_sort_cell.sv
// ----------------------------------------------------------------------------
// swm_sort_cell
// One slot of the sorted window: drops the leaving value, makes room for the
// new sample, trading entries with its two neighbors.
// ----------------------------------------------------------------------------
module swm_sort_cell (
  input  logic                              clk,
  input  logic                              rst_n,
  input  swm_pkg::cell_ctrl_t               ctrl,
  input  swm_pkg::link_t                    from_above,
  input  swm_pkg::link_t                    from_below,
  output swm_pkg::link_t                    to_below,
  output swm_pkg::link_t                    to_above,
  output logic signed [swm_pkg::DATA_W-1:0] val,
  output logic                              vld
);

  logic signed [swm_pkg::DATA_W-1:0] val_r;
  logic signed [swm_pkg::DATA_W-1:0] val_nxt;
  logic                              vld_r;
  logic                              vld_nxt;
  logic                              vld_eff;
  logic                              le;
  logic                              lt;
  logic                              keep;
  swm_pkg::link_t                    shifted;

  always_comb begin
    vld_eff = vld_r & ~ctrl.clear;
    le      = vld_eff & ($signed(val_r) <= $signed(ctrl.sample));
    lt      = vld_eff & ($signed(val_r) < $signed(ctrl.old_val));
    // at and above the leaving entry everything moves down one slot
    keep    = ~ctrl.remove | lt;

    to_below.val = val_r;
    to_below.vld = vld_eff;
    to_below.le  = le;

    shifted.val = keep ? val_r   : from_above.val;
    shifted.vld = keep ? vld_eff : from_above.vld;
    shifted.le  = keep ? le      : from_above.le;
    to_above    = shifted;

    // insert: stay, take the new sample, or move up one slot
    if (shifted.le) begin
      val_nxt = shifted.val;
      vld_nxt = shifted.vld;
    end else if (from_below.le) begin
      val_nxt = ctrl.sample;
      vld_nxt = 1'b1;
    end else begin
      val_nxt = from_below.val;
      vld_nxt = from_below.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (ctrl.wipe) begin
      vld_r <= 1'b0;
    end else if (ctrl.load) begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      val_r <= val_nxt;
    end
  end

  assign val = val_r;
  assign vld = vld_r;

endmodule

FILE: design/swm_delay_cell.sv
// ----------------------------------------------------------------------------
// swm_delay_cell
// One stage of the arrival-order delay line that finds the leaving sample.
// ----------------------------------------------------------------------------
module swm_delay_cell (
  input  logic                              clk,
  input  logic                              load,
  input  logic                              inject,
  input  logic signed [swm_pkg::DATA_W-1:0] sample,
  input  logic signed [swm_pkg::DATA_W-1:0] upper,
  output logic signed [swm_pkg::DATA_W-1:0] val
);

  logic signed [swm_pkg::DATA_W-1:0] val_r;
  logic signed [swm_pkg::DATA_W-1:0] val_nxt;

  assign val_nxt = inject ? sample : upper;

  always_ff @(posedge clk) begin
    if (load) begin
      val_r <= val_nxt;
    end
  end

  assign val = val_r;

endmodule

FILE: design/sliding_window_median_top.sv
// ----------------------------------------------------------------------------
// sliding_window_median_top
// Lower median over the last window_size signed samples.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one sample item per handshake; first_sample set empties the
//   window before that sample. out_ch carries one median item for every
//   sample that leaves the window full, nothing before that.
//   cfg_ch writes window_size (0 acts as 1, above 64 acts as 64) and empties
//   the window; write it only while no item is in flight.
// Throughput: one sample per cycle while in_ch.ready is high. Each sample
//   updates a chain of 64 sort cells; a parallel delay line of 64 stages
//   gives the value that leaves the window, and the median is picked from
//   the updated chain into the output register.
// Stall: the output register holds while out_ch.ready is low; samples are
//   still taken until one gives a median, then in_ch.ready drops until the
//   register drains.
// Reset: rst_n (synchronous) empties the window and sets window_size to 3.
// ----------------------------------------------------------------------------
module sliding_window_median_top (
  input  logic       clk,
  input  logic       rst_n,
  swm_in_if.sink     in_ch,
  swm_out_if.source  out_ch,
  swm_cfg_if.sink    cfg_ch
);

  localparam int N = swm_pkg::WINDOW_MAX;

  logic [swm_pkg::CNT_W-1:0]          ws_r;
  logic [swm_pkg::CNT_W-1:0]          fill_r;
  logic [swm_pkg::CNT_W-1:0]          fill_nxt;
  logic [swm_pkg::CNT_W-1:0]          fill_base;
  logic [swm_pkg::CNT_W-1:0]          w_eff;
  logic [swm_pkg::IDX_W-1:0]          inj_pos;
  logic [swm_pkg::IDX_W-1:0]          med_idx;
  logic                               sel_pending_r;
  logic                               sel_pending_nxt;
  logic                               out_valid_r;
  logic                               out_valid_nxt;
  logic signed [swm_pkg::DATA_W-1:0]  out_median_r;
  logic signed [swm_pkg::DATA_W-1:0]  sel_val;
  logic                               out_can_load;
  logic                               load;
  logic                               remove;
  logic                               has_result;
  logic                               cfg_wr;
  swm_pkg::cell_ctrl_t                ctrl;

  swm_pkg::link_t                     dn_link [N];
  swm_pkg::link_t                     up_link [N];
  logic signed [swm_pkg::DATA_W-1:0]  cell_val [N];
  logic [N-1:0]                       cell_vld;
  logic signed [swm_pkg::DATA_W-1:0]  dly_val [N];
  logic [N-1:0]                       inject;

  assign w_eff   = swm_pkg::eff_size(ws_r);
  assign inj_pos = swm_pkg::IDX_W'(w_eff - swm_pkg::CNT_W'(1));
  assign med_idx = inj_pos >> 1;

  assign out_can_load = ~out_valid_r | out_ch.ready;
  assign in_ch.ready  = ~sel_pending_r | out_can_load;
  assign load         = in_ch.valid & in_ch.ready;
  assign cfg_ch.ready = 1'b1;
  assign cfg_wr       = cfg_ch.valid;

  assign fill_base  = in_ch.first_sample ? '0 : fill_r;
  assign remove     = (fill_base == w_eff);
  assign fill_nxt   = remove ? fill_base : fill_base + swm_pkg::CNT_W'(1);
  assign has_result = (fill_nxt == w_eff);

  always_comb begin
    ctrl.sample  = in_ch.sample;
    ctrl.old_val = dly_val[0];
    ctrl.clear   = in_ch.first_sample;
    ctrl.remove  = remove;
    ctrl.load    = load;
    ctrl.wipe    = cfg_wr;
  end

  genvar k;
  generate
    for (k = 0; k < N; k++) begin : g_cell
      swm_pkg::link_t                    above;
      swm_pkg::link_t                    below;
      logic signed [swm_pkg::DATA_W-1:0] dly_upper;

      if (k == N - 1) begin : g_top
        assign above     = '0;
        assign dly_upper = '0;
      end else begin : g_mid
        assign above     = dn_link[k+1];
        assign dly_upper = dly_val[k+1];
      end

      if (k == 0) begin : g_bot
        // below the first slot everything counts as not above the sample
        assign below = '{val: '0, vld: 1'b0, le: 1'b1};
      end else begin : g_up
        assign below = up_link[k-1];
      end

      assign inject[k] = (inj_pos == swm_pkg::IDX_W'(k));

      swm_sort_cell u_sort (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .from_above (above),
        .from_below (below),
        .to_below   (dn_link[k]),
        .to_above   (up_link[k]),
        .val        (cell_val[k]),
        .vld        (cell_vld[k])
      );

      swm_delay_cell u_dly (
        .clk    (clk),
        .load   (load),
        .inject (inject[k]),
        .sample (in_ch.sample),
        .upper  (dly_upper),
        .val    (dly_val[k])
      );
    end
  endgenerate

  // pick the lower median slot out of the chain
  always_comb begin
    sel_val = '0;
    for (int i = 0; i < N; i++) begin
      if (med_idx == swm_pkg::IDX_W'(i)) begin
        sel_val = sel_val | cell_val[i];
      end
    end
  end

  always_comb begin
    sel_pending_nxt = sel_pending_r;
    if (load) begin
      sel_pending_nxt = has_result;
    end else if (out_can_load) begin
      sel_pending_nxt = 1'b0;
    end

    out_valid_nxt = out_valid_r;
    if (sel_pending_r && out_can_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ws_r          <= swm_pkg::WS_RESET;
      fill_r        <= '0;
      sel_pending_r <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      sel_pending_r <= sel_pending_nxt;
      out_valid_r   <= out_valid_nxt;
      if (cfg_wr) begin
        ws_r   <= cfg_ch.window_size;
        fill_r <= '0;
      end else if (load) begin
        fill_r <= fill_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (sel_pending_r && out_can_load) begin
      out_median_r <= sel_val;
    end
  end

  assign out_ch.valid  = out_valid_r;
  assign out_ch.median = out_median_r;

  // window never holds more entries than its size
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= w_eff)
    else $error("fill count above window size");

  // occupied slots of the chain match the fill count
  a_fill_match: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(cell_vld) == 32'(fill_r))
    else $error("sort chain occupancy differs from fill count");

  // a pending selection must not be overrun while the output is blocked
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (sel_pending_r && out_valid_r && !out_ch.ready) |-> !in_ch.ready)
    else $error("sample accepted while median selection is blocked");

  // every new output item comes from a pending selection
  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(sel_pending_r))
    else $error("output item without a selected median");

endmodule
